[rtl/core/rsm_pkg.sv]
package rsm_pkg;

   typedef enum logic [3:0] {
      CMD_SHIFT_RIGHT  = 4'd0,
      CMD_SHIFT_LEFT   = 4'd1,
      CMD_READ         = 4'd2,
      CMD_WRITE        = 4'd3,
      CMD_INSERT_RIGHT = 4'd4,
      CMD_INSERT_LEFT  = 4'd5,
      CMD_DELETE_RIGHT = 4'd6,
      CMD_DELETE_LEFT  = 4'd7,
      CMD_OVERWRITE    = 4'd8
   } command_type;

   localparam int unsigned CsrAddrWidth = 4;

   localparam logic [CsrAddrWidth-1:0] CSR_WRITE_MODE      = 4'h0;
   localparam logic [CsrAddrWidth-1:0] CSR_SEGMENT_WIDTH   = 4'h4;
   localparam logic [CsrAddrWidth-1:0] CSR_RESERVED_LENGTH = 4'h8;

   localparam logic [5:0] SEGMENT_WIDTH_RESET = 6'd7;

   // broadcast to every cell of the track
   typedef struct packed {
      logic        fire;
      command_type command;
      logic        pos_ok;
      logic        data;
   } cell_ctrl_type;

   // where a cell sits relative to the addressed port
   typedef struct packed {
      logic below;
      logic at;
      logic above;
   } pos_rel_type;

endpackage

[rtl/core/rsm_channels.sv]
interface rsm_req_intf;
   logic       valid;
   logic       ready;
   logic [3:0] command;
   logic [1:0] port;
   logic       data;

   modport source (output valid, output command, output port, output data, input ready);
   modport sink   (input valid, input command, input port, input data, output ready);
endinterface

interface rsm_rsp_intf;
   logic valid;
   logic ready;
   logic read_bit;

   modport source (output valid, output read_bit, input ready);
   modport sink   (input valid, input read_bit, output ready);
endinterface

[rtl/core/rsm_port_calc.sv]
module rsm_port_calc
   import rsm_pkg::*;
#(
   parameter int unsigned TRACK_LENGTH = 64,
   parameter int unsigned NUM_PORTS    = 4,
   localparam int unsigned PosWidth    = (TRACK_LENGTH > 2) ? $clog2(TRACK_LENGTH) : 1
) (
   input  logic                write_mode,
   input  logic [5:0]          segment_width,
   input  logic [6:0]          reserved_length,
   input  logic [1:0]          port,
   output logic [PosWidth-1:0] pos,
   output logic                pos_ok
);

   localparam int unsigned CalcWidth  = PosWidth + 10;
   localparam int unsigned AvailWidth = $clog2(TRACK_LENGTH + 1);
   localparam int unsigned DivShift   = AvailWidth + $clog2(NUM_PORTS);
   localparam int unsigned RecipWidth = AvailWidth + 1;
   localparam int unsigned ProdWidth  = AvailWidth + RecipWidth;
   // reciprocal of the port count, exact for every spacing the track allows
   localparam logic [RecipWidth-1:0] DivRecip =
      RecipWidth'(((64'd1 << DivShift) + 64'(NUM_PORTS) - 64'd1) / 64'(NUM_PORTS));

   logic [CalcWidth-1:0] port_ext;
   logic [CalcWidth-1:0] perm_pos;
   logic [CalcWidth-1:0] avail;
   logic [ProdWidth-1:0] div_prod;
   logic [CalcWidth-1:0] gap;
   logic [CalcWidth-1:0] even_pos;
   logic [CalcWidth-1:0] raw_pos;
   logic                 port_ok;
   logic                 even_ok;

   always_comb begin
      port_ext = CalcWidth'(port);
      port_ok  = port_ext < CalcWidth'(NUM_PORTS);
      perm_pos = port_ext * (CalcWidth'(segment_width) + CalcWidth'(1));
      avail    = CalcWidth'(TRACK_LENGTH) - CalcWidth'(reserved_length);
      div_prod = ProdWidth'(avail[AvailWidth-1:0]) * ProdWidth'(DivRecip);
      gap      = CalcWidth'(div_prod >> DivShift);
      even_ok  = (CalcWidth'(reserved_length) < CalcWidth'(TRACK_LENGTH)) && (gap != '0);
      even_pos = gap * (port_ext + CalcWidth'(1)) - CalcWidth'(1);
      raw_pos  = write_mode ? perm_pos : even_pos;
      pos_ok   = port_ok && (write_mode || even_ok) && (raw_pos < CalcWidth'(TRACK_LENGTH));
      pos      = raw_pos[PosWidth-1:0];
   end

endmodule

[rtl/core/rsm_cell.sv]
module rsm_cell
   import rsm_pkg::*;
#(
   parameter bit FIRST = 1'b0,
   parameter bit LAST  = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  pos_rel_type   rel,
   input  logic          lower_bit,
   input  logic          upper_bit,
   output logic          bit_out
);

   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (ctrl.fire) begin
         case (ctrl.command)
            CMD_SHIFT_RIGHT: begin
               if (!FIRST) bit_in = lower_bit;
            end
            CMD_SHIFT_LEFT: begin
               if (!LAST) bit_in = upper_bit;
            end
            CMD_WRITE: begin
               if (ctrl.pos_ok && rel.at && ctrl.data) bit_in = 1'b1;
            end
            CMD_INSERT_RIGHT: begin
               if (ctrl.pos_ok && rel.above) bit_in = lower_bit;
               else if (ctrl.pos_ok && rel.at) bit_in = ctrl.data;
            end
            CMD_INSERT_LEFT: begin
               if (ctrl.pos_ok && rel.below) bit_in = upper_bit;
               else if (ctrl.pos_ok && rel.at) bit_in = ctrl.data;
            end
            CMD_DELETE_RIGHT: begin
               if (ctrl.pos_ok && (rel.below || rel.at)) bit_in = lower_bit;
            end
            CMD_DELETE_LEFT: begin
               if (ctrl.pos_ok && (rel.above || rel.at)) bit_in = upper_bit;
            end
            CMD_OVERWRITE: begin
               if (ctrl.pos_ok && rel.at) bit_in = ctrl.data;
            end
            default: bit_in = bit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign bit_out = bit_ff;

endmodule

[rtl/core/racetrack_shift_memory_core.sv]
// order: a beat accepted into the command register updates the track, and for a read loads the
// response register, when it fires from that register; the response register then offers the read beat
// throughput: one command per cycle, every command acting on the whole row of track cells;
// a read stalls only while the response register is full and not being taken
// reset: synchronous, clears the track to zeros and loads the register reset values
module racetrack_shift_memory_core
   import rsm_pkg::*;
#(
   parameter int unsigned TRACK_LENGTH = 64,
   parameter int unsigned NUM_PORTS    = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   rsm_req_intf.sink               req_chan,
   rsm_rsp_intf.source             rsp_chan,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int unsigned PosWidth = (TRACK_LENGTH > 2) ? $clog2(TRACK_LENGTH) : 1;

   logic       write_mode_ff;
   logic [5:0] segment_width_ff;
   logic [6:0] reserved_length_ff;

   logic                csr_write;
   logic [PosWidth-1:0] calc_pos;
   logic                calc_pos_ok;

   logic                valid_ff;
   command_type         command_ff;
   logic [PosWidth-1:0] pos_ff;
   logic                pos_ok_ff;
   logic                data_ff;

   logic                rsp_valid_ff;
   logic                rsp_bit_ff;

   logic                fire;
   logic                req_take;
   cell_ctrl_type       ctrl;
   logic [TRACK_LENGTH-1:0] track;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_mode_ff      <= 1'b0;
         segment_width_ff   <= SEGMENT_WIDTH_RESET;
         reserved_length_ff <= 7'd0;
      end else if (csr_write) begin
         case (csr_paddr)
            CSR_WRITE_MODE:      write_mode_ff      <= csr_pwdata[0];
            CSR_SEGMENT_WIDTH:   segment_width_ff   <= csr_pwdata[5:0];
            CSR_RESERVED_LENGTH: reserved_length_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         CSR_WRITE_MODE:      csr_prdata = 32'(write_mode_ff);
         CSR_SEGMENT_WIDTH:   csr_prdata = 32'(segment_width_ff);
         CSR_RESERVED_LENGTH: csr_prdata = 32'(reserved_length_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // port position lookup
   rsm_port_calc #(
      .TRACK_LENGTH (TRACK_LENGTH),
      .NUM_PORTS    (NUM_PORTS)
   ) u_port_calc (
      .write_mode      (write_mode_ff),
      .segment_width   (segment_width_ff),
      .reserved_length (reserved_length_ff),
      .port            (req_chan.port),
      .pos             (calc_pos),
      .pos_ok          (calc_pos_ok)
   );

   // command stage
   assign fire = valid_ff && ((command_ff != CMD_READ) || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !valid_ff || fire;
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         command_ff <= command_type'(req_chan.command);
         pos_ff     <= calc_pos;
         pos_ok_ff  <= calc_pos_ok;
         data_ff    <= req_chan.data;
      end
   end

   // track cells
   always_comb begin
      ctrl.fire    = fire;
      ctrl.command = command_ff;
      ctrl.pos_ok  = pos_ok_ff;
      ctrl.data    = data_ff;
   end

   for (genvar i = 0; i < TRACK_LENGTH; i++) begin : g_cell
      pos_rel_type rel;
      logic        lower_bit;
      logic        upper_bit;

      always_comb begin
         rel.below = PosWidth'(i) < pos_ff;
         rel.at    = PosWidth'(i) == pos_ff;
         rel.above = PosWidth'(i) > pos_ff;
      end

      if (i == 0) begin : g_first
         assign lower_bit = 1'b0;
      end else begin : g_lower
         assign lower_bit = track[i-1];
      end

      if (i == TRACK_LENGTH - 1) begin : g_last
         assign upper_bit = 1'b0;
      end else begin : g_upper
         assign upper_bit = track[i+1];
      end

      rsm_cell #(
         .FIRST (i == 0),
         .LAST  (i == TRACK_LENGTH - 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .rel       (rel),
         .lower_bit (lower_bit),
         .upper_bit (upper_bit),
         .bit_out   (track[i])
      );
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && (command_ff == CMD_READ)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && (command_ff == CMD_READ)) begin
         rsp_bit_ff <= pos_ok_ff && track[pos_ff];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.read_bit = rsp_bit_ff;

endmodule

[verif/testbench.sv]
module testbench
   import rsm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TRACK_LEN   = 64;
   localparam int PORT_COUNT  = 4;
   localparam int IDLE_PCT    = 34;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOWN_LIMIT = 10;

   // codes the block must ignore
   localparam logic [3:0] CMD_UNKNOWN_LOW  = 4'd9;
   localparam logic [3:0] CMD_UNKNOWN_HIGH = 4'd15;

   typedef struct packed {
      logic [3:0] command;
      logic [1:0] port;
      logic       data;
   } track_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   rsm_req_intf req_if ();
   rsm_rsp_intf rsp_if ();

   racetrack_shift_memory_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // track image and register copies
   logic [TRACK_LEN-1:0] track_model;
   logic                 cfg_mode;
   logic [5:0]           cfg_segment;
   logic [6:0]           cfg_reserved;

   track_cmd_type pending_cmds[$];
   logic          expected_bits[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   bit            steady;
   bit            rsp_hold_go;
   bit            rsp_hold_used;
   int            rsp_hold_left;

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (mismatch_count < SHOWN_LIMIT)
         $display("mismatch %s: expected %0h, got %0h", what, want, got);
      mismatch_count++;
   endfunction

   function automatic int port_position(logic [1:0] port);
      int pos;
      int avail;
      int gap;
      if (int'(port) >= PORT_COUNT)
         return -1;
      if (cfg_mode) begin
         pos = int'(port) * (int'(cfg_segment) + 1);
      end else begin
         avail = TRACK_LEN - int'(cfg_reserved);
         gap = (avail > 0) ? avail / PORT_COUNT : 0;
         pos = gap - 1 + int'(port) * gap;
      end
      if (pos < 0 || pos >= TRACK_LEN)
         return -1;
      return pos;
   endfunction

   function automatic void apply_command(logic [3:0] command, logic [1:0] port, logic data);
      int pos;
      int i;
      pos = port_position(port);
      case (command)
         CMD_SHIFT_RIGHT: track_model = {track_model[TRACK_LEN-2:0], track_model[0]};
         CMD_SHIFT_LEFT:  track_model = {track_model[TRACK_LEN-1], track_model[TRACK_LEN-1:1]};
         CMD_READ:        expected_bits.push_back((pos >= 0) ? track_model[pos] : 1'b0);
         CMD_WRITE: begin
            if (pos >= 0 && data)
               track_model[pos] = 1'b1;
         end
         CMD_INSERT_RIGHT: begin
            if (pos >= 0) begin
               for (i = TRACK_LEN - 1; i > pos; i--)
                  track_model[i] = track_model[i-1];
               track_model[pos] = data;
            end
         end
         CMD_INSERT_LEFT: begin
            if (pos >= 0) begin
               for (i = 0; i < pos; i++)
                  track_model[i] = track_model[i+1];
               track_model[pos] = data;
            end
         end
         CMD_DELETE_RIGHT: begin
            if (pos >= 0) begin
               for (i = pos; i > 0; i--)
                  track_model[i] = track_model[i-1];
               track_model[0] = 1'b0;
            end
         end
         CMD_DELETE_LEFT: begin
            if (pos >= 0) begin
               for (i = pos; i < TRACK_LEN - 1; i++)
                  track_model[i] = track_model[i+1];
               track_model[TRACK_LEN-1] = 1'b0;
            end
         end
         CMD_OVERWRITE: begin
            if (pos >= 0)
               track_model[pos] = data;
         end
         default: ;
      endcase
   endfunction

   // command driver
   always @(posedge clock) begin : drive_cmds
      track_cmd_type next_cmd;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            apply_command(req_if.command, req_if.port, req_if.data);
         if (!req_if.valid || req_if.ready) begin
            if (pending_cmds.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               next_cmd = pending_cmds.pop_front();
               req_if.command <= next_cmd.command;
               req_if.port    <= next_cmd.port;
               req_if.data    <= next_cmd.data;
               req_if.valid   <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold_left <= 0;
         rsp_hold_used <= 1'b0;
      end else if (rsp_hold_go && !rsp_hold_used) begin
         rsp_hold_left <= HOLD_CYCLES;
         rsp_hold_used <= 1'b1;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= (rsp_hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   // read beat monitor
   always @(posedge clock) begin : watch_reads
      logic want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_bits.size() == 0) begin
            note_mismatch("read_bit with no read pending", 32'h0, {31'h0, rsp_if.read_bit});
         end else begin
            want = expected_bits.pop_front();
            if (rsp_if.read_bit !== want)
               note_mismatch("read_bit", {31'h0, want}, {31'h0, rsp_if.read_bit});
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("racetrack_shift_memory_core test failed");
         $finish;
      end
   end

   task automatic program_register(logic [CsrAddrWidth-1:0] addr, logic [31:0] value);
      logic [31:0] mask;
      case (addr)
         CSR_WRITE_MODE:    mask = 32'h1;
         CSR_SEGMENT_WIDTH: mask = 32'h3f;
         default:           mask = 32'h7f;
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (addr)
         CSR_WRITE_MODE:    cfg_mode     = value[0];
         CSR_SEGMENT_WIDTH: cfg_segment  = value[5:0];
         default:           cfg_reserved = value[6:0];
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if ((csr_prdata & mask) !== (value & mask))
         note_mismatch("register readback", value & mask, csr_prdata & mask);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_track_config(logic mode, logic [5:0] segment, logic [6:0] reserved);
      program_register(CSR_WRITE_MODE, {31'h0, mode});
      program_register(CSR_SEGMENT_WIDTH, {26'h0, segment});
      program_register(CSR_RESERVED_LENGTH, {25'h0, reserved});
   endtask

   task automatic queue_cmd(logic [3:0] command, logic [1:0] port, logic data);
      track_cmd_type c;
      c.command = command;
      c.port    = port;
      c.data    = data;
      pending_cmds.push_back(c);
   endtask

   // everything sent, every read returned, then a short settling wait for the last update
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_cmds.size() != 0 || req_if.valid || expected_bits.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      int done;
      int pick;
      logic [3:0] command;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 8)       command = CMD_SHIFT_RIGHT;
         else if (pick < 16) command = CMD_SHIFT_LEFT;
         else if (pick < 40) command = CMD_READ;
         else if (pick < 52) command = CMD_WRITE;
         else if (pick < 60) command = CMD_INSERT_RIGHT;
         else if (pick < 68) command = CMD_INSERT_LEFT;
         else if (pick < 74) command = CMD_DELETE_RIGHT;
         else if (pick < 80) command = CMD_DELETE_LEFT;
         else if (pick < 94) command = CMD_OVERWRITE;
         else command = 4'($urandom_range(CMD_UNKNOWN_HIGH, CMD_UNKNOWN_LOW));
         queue_cmd(command, 2'($urandom_range(3)), $urandom_range(99) < 65);
         if (command < CMD_UNKNOWN_LOW)
            done++;
      end
   endtask

   task automatic random_phase(logic mode, logic [5:0] segment, logic [6:0] reserved,
                               int count);
      set_track_config(mode, segment, reserved);
      queue_random(count);
      wait_idle();
   endtask

   initial begin
      int k;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      track_model    = '0;
      cfg_mode       = 1'b0;
      cfg_segment    = SEGMENT_WIDTH_RESET;
      cfg_reserved   = 7'd0;
      steady         = 1'b0;
      rsp_hold_go    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register reset values, ports at 15 31 47 63
      queue_cmd(CMD_WRITE, 2'd0, 1'b1);
      queue_cmd(CMD_WRITE, 2'd1, 1'b0);
      queue_cmd(CMD_OVERWRITE, 2'd1, 1'b1);
      for (k = 0; k < PORT_COUNT; k++)
         queue_cmd(CMD_READ, 2'(k), 1'b0);
      queue_cmd(CMD_INSERT_RIGHT, 2'd2, 1'b1);
      queue_cmd(CMD_INSERT_LEFT, 2'd3, 1'b1);
      queue_cmd(CMD_READ, 2'd2, 1'b1);
      queue_cmd(CMD_READ, 2'd3, 1'b0);
      queue_cmd(CMD_SHIFT_RIGHT, 2'd3, 1'b1);
      queue_cmd(CMD_READ, 2'd0, 1'b0);
      queue_cmd(CMD_SHIFT_LEFT, 2'd0, 1'b0);
      queue_cmd(CMD_DELETE_RIGHT, 2'd1, 1'b1);
      queue_cmd(CMD_DELETE_LEFT, 2'd0, 1'b0);
      queue_cmd(CMD_READ, 2'd1, 1'b0);
      queue_cmd(CMD_READ, 2'd0, 1'b1);
      queue_cmd(CMD_OVERWRITE, 2'd0, 1'b0);
      queue_cmd(CMD_READ, 2'd0, 1'b0);
      queue_cmd(CMD_UNKNOWN_LOW, 2'd3, 1'b1);
      queue_cmd(CMD_UNKNOWN_HIGH, 2'd2, 1'b1);
      queue_cmd(CMD_READ, 2'd1, 1'b1);
      wait_idle();

      // ports at 0 1 2 3, receiver holds off while reads pile up
      set_track_config(1'b1, 6'd0, 7'd0);
      steady = 1'b1;
      rsp_hold_go <= 1'b1;
      for (k = 0; k < 60; k++)
         queue_cmd((k % 3 == 0) ? CMD_WRITE : CMD_READ, 2'($urandom_range(3)), 1'b1);
      wait_idle();
      steady = 1'b0;
      queue_random(140);
      wait_idle();

      random_phase(1'b1, 6'd63, 7'd0, 150);
      random_phase(1'b1, 6'd20, 7'd64, 150);
      random_phase(1'b0, 6'd20, 7'd64, 100);
      random_phase(1'b0, 6'd5, 7'd60, 150);
      random_phase(1'b0, 6'd5, 7'd61, 60);

      steady = 1'b1;
      random_phase(1'b0, 6'd7, 7'd0, 200);
      steady = 1'b0;

      random_phase(1'b0, 6'd31, 7'd13, 150);
      for (k = 0; k < 2; k++)
         random_phase(1'($urandom_range(1)), 6'($urandom_range(63)),
                      7'($urandom_range(64)), 100);

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_bits.size() == 0)
         $display("racetrack_shift_memory_core test passed");
      else
         $display("racetrack_shift_memory_core test failed");
      $finish;
   end

endmodule
